/* sv/dltq_pkg.sv */
// Shared types and codes for the delta-list timer queue.
// No dependencies.
`default_nettype none

package dltq_pkg;

	typedef enum logic [1:0] {
		KIND_EXPIRED = 2'd0,
		KIND_ACCEPT  = 2'd1,
		KIND_REJECT  = 2'd2
	} kind_t;

	localparam logic REQ_TICK   = 1'b0;
	localparam logic REQ_INSERT = 1'b1;

endpackage

`default_nettype wire

/* sv/dltq_store.sv */
// Circular entry store of the timer queue: delta and id per entry, addressed
// relative to the head pointer. One write and one registered read per cycle.
// Depends on nothing.
`default_nettype none

module dltq_store #(
	parameter int DEPTH      = 16,
	parameter int TIME_WIDTH = 16,
	parameter int ID_WIDTH   = 8,
	localparam int PW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  pop,
	input  wire logic                  rd_en,
	input  wire logic [PW-1:0]         rd_idx,
	input  wire logic                  wr_en,
	input  wire logic [PW-1:0]         wr_idx,
	input  wire logic [TIME_WIDTH-1:0] wr_delta,
	input  wire logic [ID_WIDTH-1:0]   wr_id,
	output logic      [TIME_WIDTH-1:0] rd_delta,
	output logic      [ID_WIDTH-1:0]   rd_id
);

	logic [TIME_WIDTH-1:0] delta_mem [DEPTH];
	logic [ID_WIDTH-1:0]   id_mem    [DEPTH];
	logic [PW-1:0]         head_q;
	logic [PW:0]           rd_sum, wr_sum, head_sum;
	logic [PW-1:0]         rd_addr, wr_addr, head_next;

	always_comb begin
		rd_sum   = {1'b0, head_q} + {1'b0, rd_idx};
		wr_sum   = {1'b0, head_q} + {1'b0, wr_idx};
		head_sum = {1'b0, head_q} + (PW+1)'(1);
		rd_addr  = (rd_sum >= (PW+1)'(DEPTH)) ? PW'(rd_sum - (PW+1)'(DEPTH)) : rd_sum[PW-1:0];
		wr_addr  = (wr_sum >= (PW+1)'(DEPTH)) ? PW'(wr_sum - (PW+1)'(DEPTH)) : wr_sum[PW-1:0];
		head_next = (head_sum >= (PW+1)'(DEPTH)) ? '0 : head_sum[PW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (pop) begin
			head_q <= head_next;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			delta_mem[wr_addr] <= wr_delta;
			id_mem[wr_addr]    <= wr_id;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_delta <= delta_mem[rd_addr];
			rd_id    <= id_mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* sv/delta_list_timer_queue_unit.sv */
// Delta-list timer queue: sequencer, one compare/subtract unit, output register.
// Depends on dltq_pkg and dltq_store.
//
// Usage:
//   Input stream s_axis: tuser selects the request (tick or insert), tdata
//   carries the delay and the event id of an insert. One request is worked
//   on at a time; s_axis_tready is high only while the sequencer is idle.
//   Output stream m_axis: tuser gives the result kind (expired, accepted,
//   rejected), tdata the event id, tlast marks the final result of a request.
//   Sequencing: an insert walks the list over the single memory read port, a
//   read and a compare state per passed entry, then moves every following
//   entry down one slot with a read and a write state each, and registers its
//   result in the place state. A tick that only counts the head down is done
//   in the cycle after its transfer; a tick that expires events registers them
//   one at a time in list order. A tick on an empty queue returns nothing and
//   leaves s_axis_tready high. s_axis_tready is high again in the same cycle
//   as m_axis_tvalid of the last result of a request.
//   While the receiver stalls, the sequencer holds in the state that produces
//   the next result; a new request is taken when only the last result waits.
//   Reset empties the queue at once; the store contents need no clearing.
`default_nettype none

module delta_list_timer_queue_unit
	import dltq_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int TIME_WIDTH = 16,
	parameter int ID_WIDTH   = 8,
	localparam int IBW       = ((TIME_WIDTH + ID_WIDTH + 7) / 8) * 8,
	localparam int OBW       = ((ID_WIDTH + 7) / 8) * 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_axis_tvalid,
	output logic                s_axis_tready,
	input  wire logic [IBW-1:0] s_axis_tdata,   // delay, event_id
	input  wire logic           s_axis_tuser,   // req_type
	output logic                m_axis_tvalid,
	input  wire logic           m_axis_tready,
	output logic      [OBW-1:0] m_axis_tdata,   // out_event
	output logic      [1:0]     m_axis_tuser,   // kind
	output logic                m_axis_tlast
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [9:0] {
		S_IDLE     = 10'b00_0000_0001,
		S_WALK_RD  = 10'b00_0000_0010,
		S_WALK_CMP = 10'b00_0000_0100,
		S_SHIFT_RD = 10'b00_0000_1000,
		S_SHIFT_WR = 10'b00_0001_0000,
		S_PLACE    = 10'b00_0010_0000,
		S_REJECT   = 10'b00_0100_0000,
		S_TICK_CMP = 10'b00_1000_0000,
		S_EXP_CHK  = 10'b01_0000_0000,
		S_EXP_CMP  = 10'b10_0000_0000
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q, pos_q, i_q;
	logic [TIME_WIDTH-1:0] d_q, fol_q;
	logic [ID_WIDTH-1:0]   ev_q, pend_q;

	logic                  m_valid_q, m_last_q;
	kind_t                 m_kind_q;
	logic [ID_WIDTH-1:0]   m_ev_q;

	logic                  in_xfer, out_free, out_load;
	logic [TIME_WIDTH-1:0] in_delay;
	logic [ID_WIDTH-1:0]   in_id;
	logic [CW-1:0]         i_dec, pos_inc;

	logic                  mem_pop, mem_rd_en, mem_wr_en;
	logic [PW-1:0]         mem_rd_idx, mem_wr_idx;
	logic [TIME_WIDTH-1:0] mem_wr_delta, rd_delta;
	logic [ID_WIDTH-1:0]   mem_wr_id, rd_id;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign in_delay      = s_axis_tdata[TIME_WIDTH-1:0];
	assign in_id         = s_axis_tdata[TIME_WIDTH+ID_WIDTH-1:TIME_WIDTH];
	assign out_free      = !m_valid_q || m_axis_tready;
	assign i_dec         = i_q - CW'(1);
	assign pos_inc       = pos_q + CW'(1);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OBW'(m_ev_q);
	assign m_axis_tuser  = m_kind_q;
	assign m_axis_tlast  = m_last_q;

	always_comb begin
		mem_pop      = 1'b0;
		mem_rd_en    = 1'b0;
		mem_rd_idx   = '0;
		mem_wr_en    = 1'b0;
		mem_wr_idx   = '0;
		mem_wr_delta = rd_delta;
		mem_wr_id    = rd_id;
		out_load     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				mem_rd_en = in_xfer && (count_q != '0);
			end
			S_WALK_RD: begin
				mem_rd_en  = (pos_q != count_q);
				mem_rd_idx = pos_q[PW-1:0];
			end
			S_SHIFT_RD: begin
				mem_rd_en  = 1'b1;
				mem_rd_idx = i_dec[PW-1:0];
			end
			S_SHIFT_WR: begin
				mem_wr_en  = 1'b1;
				mem_wr_idx = i_q[PW-1:0];
				if (i_q == pos_inc) begin
					mem_wr_delta = fol_q;
				end
			end
			S_PLACE: begin
				mem_wr_en    = out_free;
				mem_wr_idx   = pos_q[PW-1:0];
				mem_wr_delta = d_q;
				mem_wr_id    = ev_q;
				out_load     = out_free;
			end
			S_REJECT: begin
				out_load = out_free;
			end
			S_TICK_CMP: begin
				if (rd_delta > TIME_WIDTH'(1)) begin
					mem_wr_en    = 1'b1;
					mem_wr_delta = rd_delta - TIME_WIDTH'(1);
				end else begin
					mem_pop = 1'b1;
				end
			end
			S_EXP_CHK: begin
				mem_rd_en = (count_q != '0);
				out_load  = (count_q == '0) && out_free;
			end
			S_EXP_CMP: begin
				mem_pop  = out_free && (rd_delta == '0);
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			m_valid_q <= out_load || (m_valid_q && !m_axis_tready);
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (s_axis_tuser == REQ_INSERT) begin
							if (count_q == CW'(DEPTH)) begin
								state_q <= S_REJECT;
							end else if (count_q == '0) begin
								state_q <= S_PLACE;
							end else begin
								state_q <= S_WALK_CMP;
							end
						end else if (count_q != '0) begin
							state_q <= S_TICK_CMP;
						end
					end
				end
				S_WALK_RD: begin
					state_q <= (pos_q == count_q) ? S_PLACE : S_WALK_CMP;
				end
				S_WALK_CMP: begin
					state_q <= (d_q > rd_delta) ? S_WALK_RD : S_SHIFT_RD;
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					state_q <= (i_dec == pos_q) ? S_PLACE : S_SHIFT_RD;
				end
				S_PLACE: begin
					if (out_free) begin
						count_q <= count_q + CW'(1);
						state_q <= S_IDLE;
					end
				end
				S_REJECT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_TICK_CMP: begin
					if (rd_delta > TIME_WIDTH'(1)) begin
						state_q <= S_IDLE;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_EXP_CHK;
					end
				end
				S_EXP_CHK: begin
					if (count_q != '0) begin
						state_q <= S_EXP_CMP;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_EXP_CMP: begin
					if (out_free) begin
						if (rd_delta == '0) begin
							count_q <= count_q - CW'(1);
							state_q <= S_EXP_CHK;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				d_q   <= in_delay;
				ev_q  <= in_id;
				pos_q <= '0;
			end
			S_WALK_CMP: begin
				if (d_q > rd_delta) begin
					d_q   <= d_q - rd_delta;
					pos_q <= pos_inc;
				end else begin
					fol_q <= rd_delta - d_q;
					i_q   <= count_q;
				end
			end
			S_SHIFT_WR: begin
				i_q <= i_dec;
			end
			S_PLACE: begin
				if (out_free) begin
					m_kind_q <= KIND_ACCEPT;
					m_ev_q   <= ev_q;
					m_last_q <= 1'b1;
				end
			end
			S_REJECT: begin
				if (out_free) begin
					m_kind_q <= KIND_REJECT;
					m_ev_q   <= ev_q;
					m_last_q <= 1'b1;
				end
			end
			S_TICK_CMP: begin
				pend_q <= rd_id;
			end
			S_EXP_CHK: begin
				if (count_q == '0 && out_free) begin
					m_kind_q <= KIND_EXPIRED;
					m_ev_q   <= pend_q;
					m_last_q <= 1'b1;
				end
			end
			S_EXP_CMP: begin
				if (out_free) begin
					m_kind_q <= KIND_EXPIRED;
					m_ev_q   <= pend_q;
					m_last_q <= (rd_delta != '0);
					pend_q   <= rd_id;
				end
			end
			default: begin
			end
		endcase
	end

	dltq_store #(
		.DEPTH      (DEPTH),
		.TIME_WIDTH (TIME_WIDTH),
		.ID_WIDTH   (ID_WIDTH)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop      (mem_pop),
		.rd_en    (mem_rd_en),
		.rd_idx   (mem_rd_idx),
		.wr_en    (mem_wr_en),
		.wr_idx   (mem_wr_idx),
		.wr_delta (mem_wr_delta),
		.wr_id    (mem_wr_id),
		.rd_delta (rd_delta),
		.rd_id    (rd_id)
	);

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for delta_list_timer_queue_unit: directed requests, then random tick
// and insert traffic with random idle gaps on both streams. A scoreboard class predicts
// every result transfer. Depends on dltq_pkg and the unit RTL.
`default_nettype none

module testbench
	import dltq_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH      = 16;
	localparam int TIME_WIDTH = 16;
	localparam int ID_WIDTH   = 8;

	typedef struct {
		kind_t            kind;
		logic [7:0]       ev;
		logic             last;
	} result_t;

	class timer_queue_checker;
		logic [TIME_WIDTH-1:0] delta_q [DEPTH];
		logic [ID_WIDTH-1:0]   id_q    [DEPTH];
		int unsigned           count;
		result_t               due_results [$];
		int                    errors;
		int                    n_ticks, n_inserts, n_expired, n_accept, n_reject;

		function new();
			count     = 0;
			errors    = 0;
			n_ticks   = 0;
			n_inserts = 0;
			n_expired = 0;
			n_accept  = 0;
			n_reject  = 0;
		endfunction

		function int outstanding();
			return due_results.size();
		endfunction

		function logic [ID_WIDTH-1:0] pop_head();
			logic [ID_WIDTH-1:0] ev;
			ev = id_q[0];
			for (int i = 1; i < count; i++) begin
				delta_q[i-1] = delta_q[i];
				id_q[i-1]    = id_q[i];
			end
			count--;
			return ev;
		endfunction

		function void note_request(logic req, logic [TIME_WIDTH-1:0] delay,
				logic [ID_WIDTH-1:0] ev);
			logic [TIME_WIDTH-1:0] d;
			int unsigned           pos;
			result_t               r;
			if (req == REQ_INSERT) begin
				n_inserts++;
				r.ev   = ev;
				r.last = 1'b1;
				if (count >= DEPTH) begin
					r.kind = KIND_REJECT;
					due_results.push_back(r);
					return;
				end
				d   = delay;
				pos = 0;
				while (pos < count && d > delta_q[pos]) begin
					d -= delta_q[pos];
					pos++;
				end
				for (int i = count; i > pos; i--) begin
					delta_q[i] = delta_q[i-1];
					id_q[i]    = id_q[i-1];
				end
				delta_q[pos] = d;
				id_q[pos]    = ev;
				count++;
				// successor now counts from the new entry
				if (pos + 1 < count)
					delta_q[pos+1] = delta_q[pos+1] - d;
				r.kind = KIND_ACCEPT;
				due_results.push_back(r);
				return;
			end
			n_ticks++;
			if (count == 0)
				return;
			if (delta_q[0] > 1) begin
				delta_q[0] = delta_q[0] - 1'b1;
				return;
			end
			r.kind = KIND_EXPIRED;
			r.ev   = pop_head();
			r.last = 1'b0;
			while (count > 0 && delta_q[0] == 0) begin
				due_results.push_back(r);
				r.ev = pop_head();
			end
			r.last = 1'b1;
			due_results.push_back(r);
		endfunction

		function void check_result(logic [1:0] kind, logic [7:0] ev, logic last);
			result_t exp;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result kind %0d event %02h last %0b",
					$time, kind, ev, last);
				errors++;
				return;
			end
			exp = due_results.pop_front();
			case (exp.kind)
				KIND_EXPIRED: n_expired++;
				KIND_ACCEPT:  n_accept++;
				default:      n_reject++;
			endcase
			if (2'(exp.kind) !== kind) begin
				$display("%0t: kind mismatch, expected %0d actual %0d", $time, exp.kind, kind);
				errors++;
			end
			if (exp.ev !== ev) begin
				$display("%0t: event mismatch, expected %02h actual %02h", $time, exp.ev, ev);
				errors++;
			end
			if (exp.last !== last) begin
				$display("%0t: last mismatch, expected %0b actual %0b", $time, exp.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // delay, event_id
	logic        s_axis_tuser;   // req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // out_event
	logic [1:0]  m_axis_tuser;   // kind
	logic        m_axis_tlast;

	timer_queue_checker sb;
	logic               no_idle;

	delta_list_timer_queue_unit #(
		.DEPTH     (DEPTH),
		.TIME_WIDTH(TIME_WIDTH),
		.ID_WIDTH  (ID_WIDTH)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 40)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_request(logic req, logic [15:0] delay, logic [7:0] ev);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = req;
		s_axis_tdata  = {ev, delay};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_request(req, delay, ev);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid = 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
	endtask

	task automatic send_random(int unsigned insert_bias);
		int          r;
		logic        req;
		logic [15:0] delay;
		req = ($urandom_range(0, 99) < insert_bias) ? REQ_INSERT : REQ_TICK;
		r   = $urandom_range(0, 99);
		if (r < 80)
			delay = 16'($urandom_range(0, 6));
		else if (r < 96)
			delay = 16'($urandom_range(0, 60));
		else
			delay = 16'($urandom_range(0, 65535));
		send_request(req, delay, 8'($urandom_range(0, 255)));
	endtask

	// receiver side
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				m_axis_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			repeat ($urandom_range(0, 8)) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
	end

	initial begin
		#5_000_000;
		$display("delta_list_timer_queue_unit regression: fail");
		$finish;
	end

	initial begin
		int unsigned bias;
		sb            = new();
		no_idle       = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser  = REQ_TICK;
		s_axis_tdata  = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty tick, zero delay, head at one, head above one, equal delays, tail insert
		send_request(REQ_TICK,   16'd0,     8'h00);
		send_request(REQ_INSERT, 16'd0,     8'h00);
		send_request(REQ_TICK,   16'd0,     8'h00);
		send_request(REQ_INSERT, 16'd1,     8'h01);
		send_request(REQ_INSERT, 16'd3,     8'h02);
		send_request(REQ_INSERT, 16'd3,     8'h03);
		send_request(REQ_INSERT, 16'hFFFF,  8'hFF);
		send_request(REQ_TICK,   16'hFFFF,  8'hFF);
		send_request(REQ_TICK,   16'd0,     8'h00);
		send_request(REQ_TICK,   16'd0,     8'h00);
		// fill up, then a rejected insert
		for (int i = 0; i < DEPTH - 1; i++)
			send_request(REQ_INSERT, 16'(i / 3), 8'(8'h10 + i));
		send_request(REQ_INSERT, 16'd2,     8'hAA);
		send_request(REQ_TICK,   16'd0,     8'h55);
		drain_results();

		for (int n = 0; n < 155; n++) begin
			if (n % 20 == 0) begin
				bias    = $urandom_range(20, 85);
				no_idle = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 3) == 0)
					drain_results();
			end
			send_random(bias);
		end
		no_idle = 1'b0;
		drain_results();
		repeat (2 * DEPTH + 8) @(posedge clk);

		$display("ran %0d ticks and %0d inserts with random gaps on both streams",
			sb.n_ticks, sb.n_inserts);
		$display("checked %0d expiries, %0d accepted and %0d rejected inserts",
			sb.n_expired, sb.n_accept, sb.n_reject);
		if (sb.errors == 0)
			$display("delta_list_timer_queue_unit regression: pass");
		else
			$display("delta_list_timer_queue_unit regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
sv/dltq_pkg.sv
sv/dltq_store.sv
sv/delta_list_timer_queue_unit.sv
bench/testbench.sv
